FILE: hdl/atbp_pkg.sv
// shared types, constants and the substring matcher step for the at line battery parser
// no dependencies; used by the top level, atbp_scan, atbp_num and atbp_decide
package atbp_pkg;

    localparam int PatW = 96;

    // patterns right-aligned, first character in the highest used byte
    localparam logic [PatW-1:0] PAT_PHONE  = "+iphoneaccev";
    localparam logic [PatW-1:0] PAT_CIND   = "+cind:";
    localparam logic [PatW-1:0] PAT_CIEV   = "+ciev";
    localparam logic [PatW-1:0] PAT_XEVENT = "+xevent";
    localparam logic [PatW-1:0] PAT_BIEV   = "+biev";
    localparam logic [PatW-1:0] PAT_BATT   = "batt";

    localparam logic [3:0] LEN_PHONE  = 4'd12;
    localparam logic [3:0] LEN_CIND   = 4'd6;
    localparam logic [3:0] LEN_CIEV   = 4'd5;
    localparam logic [3:0] LEN_XEVENT = 4'd7;
    localparam logic [3:0] LEN_BIEV   = 4'd5;
    localparam logic [3:0] LEN_BATT   = 4'd4;

    localparam int SEEN_PHONE  = 0;
    localparam int SEEN_CIND   = 1;
    localparam int SEEN_CIEV   = 2;
    localparam int SEEN_XEVENT = 3;
    localparam int SEEN_BIEV   = 4;
    localparam int SEEN_BATT   = 5;
    localparam int SEEN_PUNCT  = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    localparam logic [6:0] NUM_SAT   = 7'd101;
    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam logic [6:0] AT_SMALL  = 7'd9;
    localparam logic [6:0] CIND_MAX  = 7'd5;
    localparam logic [6:0] AT_SCALE  = 7'd10;
    localparam logic [6:0] CIND_SCALE = 7'd20;
    localparam logic [1:0] CNT_MAX   = 2'd2;

    typedef struct packed {
        logic [3:0] pos;
        logic       hit;
    } t_adv;

    // per-line number summary after the pending number is closed
    typedef struct packed {
        logic [1:0] count;
        logic [6:0] last;
        logic [6:0] last_in;
        logic       found;
    } t_num_sum;

    typedef struct packed {
        logic       valid;
        logic [6:0] pct;
    } t_result;

    function automatic logic [7:0] fold_case(input logic [7:0] ch);
        logic [7:0] r;
        r = ch;
        if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
            r = ch + CASE_OFS;
        end
        return r;
    endfunction

    // no pattern has a proper prefix equal to a suffix, so a miss restarts at 0 or 1
    function automatic t_adv match_adv(input logic [3:0] pos, input logic [7:0] ch,
                                       input logic [PatW-1:0] pat, input logic [3:0] len);
        logic [3:0] p;
        logic [3:0] idx;
        logic [3:0] lst;
        logic [7:0] want;
        logic [7:0] first;
        t_adv       r;
        p     = (pos >= len) ? 4'd0 : pos;
        idx   = len - 4'd1 - p;
        lst   = len - 4'd1;
        want  = pat[{idx, 3'b000} +: 8];
        first = pat[{lst, 3'b000} +: 8];
        r.hit = 1'b0;
        if (ch == want) begin
            if (p + 4'd1 == len) begin
                r.hit = 1'b1;
                r.pos = 4'd0;
            end else begin
                r.pos = p + 4'd1;
            end
        end else begin
            r.pos = (ch == first) ? 4'd1 : 4'd0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/at_line_battery_percent_parse.sv
// AT response line battery parser: takes one character word per cycle and, on the line-end
// word, returns one result word with a validity flag and the battery percent (0..100).
// An accepted word first goes into the input register; from there the matchers, number
// accumulator and decision work in a single pass into the result register.
// Sustained rate is one word per cycle; a line-end word stays in the input register only
// while the previous result has not yet been taken. Characters never produce a result.
// Depends on atbp_pkg, atbp_scan, atbp_num and atbp_decide.
module at_line_battery_percent_parse import atbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_byte
    input  logic       i_s_tlast,   // end of line
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] battery_percent, [7] zero
    output logic       o_m_tuser    // [0] percent_valid
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid, n_out_valid;
    t_result    r_out, n_out;

    logic       out_free;
    logic       step;
    logic       take;
    logic [6:0] seen;
    t_num_sum   sum;
    t_result    res;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || step;
    assign take       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    atbp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_end   (r_in_last),
        .i_ch    (r_in_char),
        .o_seen  (seen)
    );

    atbp_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_end   (r_in_last),
        .i_ch    (r_in_char),
        .o_sum   (sum)
    );

    atbp_decide u_decide (
        .i_seen (seen),
        .i_sum  (sum),
        .o_res  (res)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_out       = r_out;
        if (step && r_in_last) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.pct};
    assign o_m_tuser  = r_out.valid;

endmodule

FILE: hdl/atbp_scan.sv
// substring matchers and seen flags of one line
// depends on atbp_pkg
module atbp_scan import atbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_end,
    input  logic [7:0] i_ch,
    output logic [6:0] o_seen
);

    logic [3:0] r_phone, n_phone;
    logic [2:0] r_cind, n_cind;
    logic [2:0] r_ciev, n_ciev;
    logic [2:0] r_xev, n_xev;
    logic [2:0] r_biev, n_biev;
    logic [2:0] r_batt, n_batt;
    logic [6:0] r_seen, n_seen;

    logic [7:0] ch;
    t_adv a_phone, a_cind, a_ciev, a_xev, a_biev, a_batt;

    always_comb begin
        ch      = fold_case(i_ch);
        a_phone = match_adv(r_phone, ch, PAT_PHONE, LEN_PHONE);
        a_cind  = match_adv({1'b0, r_cind}, ch, PAT_CIND, LEN_CIND);
        a_ciev  = match_adv({1'b0, r_ciev}, ch, PAT_CIEV, LEN_CIEV);
        a_xev   = match_adv({1'b0, r_xev}, ch, PAT_XEVENT, LEN_XEVENT);
        a_biev  = match_adv({1'b0, r_biev}, ch, PAT_BIEV, LEN_BIEV);
        a_batt  = match_adv({1'b0, r_batt}, ch, PAT_BATT, LEN_BATT);

        n_phone = r_phone;
        n_cind  = r_cind;
        n_ciev  = r_ciev;
        n_xev   = r_xev;
        n_biev  = r_biev;
        n_batt  = r_batt;
        n_seen  = r_seen;
        if (i_step) begin
            if (i_end) begin
                n_phone = '0;
                n_cind  = '0;
                n_ciev  = '0;
                n_xev   = '0;
                n_biev  = '0;
                n_batt  = '0;
                n_seen  = '0;
            end else begin
                n_phone = a_phone.pos;
                n_cind  = a_cind.pos[2:0];
                n_ciev  = a_ciev.pos[2:0];
                n_xev   = a_xev.pos[2:0];
                n_biev  = a_biev.pos[2:0];
                n_batt  = a_batt.pos[2:0];
                n_seen[SEEN_PHONE]  = r_seen[SEEN_PHONE]  | a_phone.hit;
                n_seen[SEEN_CIND]   = r_seen[SEEN_CIND]   | a_cind.hit;
                n_seen[SEEN_CIEV]   = r_seen[SEEN_CIEV]   | a_ciev.hit;
                n_seen[SEEN_XEVENT] = r_seen[SEEN_XEVENT] | a_xev.hit;
                n_seen[SEEN_BIEV]   = r_seen[SEEN_BIEV]   | a_biev.hit;
                n_seen[SEEN_BATT]   = r_seen[SEEN_BATT]   | a_batt.hit;
                // a double quote, an opening parenthesis or a dash counts
                if (ch inside {CH_QUOTE, CH_LPAREN, CH_DASH}) begin
                    n_seen[SEEN_PUNCT] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phone <= '0;
            r_cind  <= '0;
            r_ciev  <= '0;
            r_xev   <= '0;
            r_biev  <= '0;
            r_batt  <= '0;
            r_seen  <= '0;
        end else begin
            r_phone <= n_phone;
            r_cind  <= n_cind;
            r_ciev  <= n_ciev;
            r_xev   <= n_xev;
            r_biev  <= n_biev;
            r_batt  <= n_batt;
            r_seen  <= n_seen;
        end
    end

    assign o_seen = r_seen;

endmodule

FILE: hdl/atbp_num.sv
// decimal number extraction with saturation at 101, plus per-line number summary
// depends on atbp_pkg
module atbp_num import atbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_end,
    input  logic [7:0] i_ch,
    output t_num_sum   o_sum
);

    logic [6:0] r_acc, n_acc;
    logic       r_inside, n_inside;
    logic [1:0] r_count, n_count;
    logic [6:0] r_last, n_last;
    logic [6:0] r_last_in, n_last_in;
    logic       r_found, n_found;

    t_num_sum   fin;
    logic [6:0] base;
    logic [9:0] grown;
    logic [3:0] digit;

    // the summary as it stands once a pending number is closed
    always_comb begin
        fin.count   = r_count;
        fin.last    = r_last;
        fin.last_in = r_last_in;
        fin.found   = r_found;
        if (r_inside) begin
            fin.last = r_acc;
            if (r_acc <= PCT_MAX) begin
                fin.last_in = r_acc;
                fin.found   = 1'b1;
            end
            if (r_count < CNT_MAX) begin
                fin.count = r_count + 2'd1;
            end
        end
    end

    always_comb begin
        base  = r_inside ? r_acc : 7'd0;
        digit = i_ch[3:0] - CH_ZERO[3:0];
        grown = {3'b000, base} * 10'd10 + {6'b000000, digit};

        n_acc     = r_acc;
        n_inside  = r_inside;
        n_count   = r_count;
        n_last    = r_last;
        n_last_in = r_last_in;
        n_found   = r_found;
        if (i_step) begin
            if (i_end) begin
                n_acc     = '0;
                n_inside  = 1'b0;
                n_count   = '0;
                n_last    = '0;
                n_last_in = '0;
                n_found   = 1'b0;
            end else if (i_ch inside {[CH_ZERO:CH_NINE]}) begin
                n_inside = 1'b1;
                if (base < NUM_SAT) begin
                    n_acc = (grown > {3'b000, NUM_SAT}) ? NUM_SAT : grown[6:0];
                end else begin
                    n_acc = base;
                end
            end else begin
                n_acc     = '0;
                n_inside  = 1'b0;
                n_count   = fin.count;
                n_last    = fin.last;
                n_last_in = fin.last_in;
                n_found   = fin.found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_inside  <= 1'b0;
            r_count   <= '0;
            r_last    <= '0;
            r_last_in <= '0;
            r_found   <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_inside  <= n_inside;
            r_count   <= n_count;
            r_last    <= n_last;
            r_last_in <= n_last_in;
            r_found   <= n_found;
        end
    end

    assign o_sum = fin;

endmodule

FILE: hdl/atbp_decide.sv
// line-end priority decision and percent normalization
// depends on atbp_pkg
module atbp_decide import atbp_pkg::*; (
    input  logic [6:0] i_seen,
    input  t_num_sum   i_sum,
    output t_result    o_res
);

    logic       use_in;
    logic [6:0] v;
    logic       at_ok;
    logic [6:0] at_pct;
    logic [6:0] cind_pct;

    always_comb begin
        use_in   = !(i_seen[SEEN_PHONE] || i_seen[SEEN_CIND] || i_seen[SEEN_CIEV]);
        v        = use_in ? i_sum.last_in : i_sum.last;
        at_ok    = (v <= PCT_MAX);
        at_pct   = (v <= AT_SMALL) ? v * AT_SCALE : v;
        cind_pct = (v <= CIND_MAX) ? v * CIND_SCALE : at_pct;

        o_res.valid = 1'b0;
        o_res.pct   = '0;
        if (i_sum.count != 2'd0) begin
            if (i_seen[SEEN_PHONE]) begin
                o_res.valid = (i_sum.count >= CNT_MAX) && at_ok;
                o_res.pct   = at_pct;
            end else if (i_seen[SEEN_CIND]) begin
                o_res.valid = !i_seen[SEEN_PUNCT] && at_ok;
                o_res.pct   = cind_pct;
            end else if (i_seen[SEEN_CIEV]) begin
                o_res.valid = at_ok;
                o_res.pct   = cind_pct;
            end else if (i_seen[SEEN_XEVENT] || i_seen[SEEN_BIEV] || i_seen[SEEN_BATT]) begin
                o_res.valid = i_sum.found && at_ok;
                o_res.pct   = at_pct;
            end
        end
        if (!o_res.valid) begin
            o_res.pct = '0;
        end
    end

endmodule

FILE: hdl/atbp_checker.sv
// port-level checks for the at line battery parser, bound to the top level
// depends on at_line_battery_percent_parse
module atbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser
);

    // no result survives reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result word shown right after reset");

    // a held result word keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    // an invalid result carries zero percent
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 8'd0)
        else $error("invalid result with nonzero percent");

    // a valid percent never exceeds full charge
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 8'd100)
        else $error("percent above 100");

    // a second line-end word cannot pass the input side while the previous one waits behind a held result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_s_tvalid && o_s_tready && i_s_tlast) && o_m_tvalid && !i_m_tready
        |-> !(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("second line end taken while result stalled");

endmodule

bind at_line_battery_percent_parse atbp_checker u_atbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
